// ----- sv/stcpf_pkg.sv -----
// Shared types and constants for the six-tap clamped pixel filter.
// No dependencies; imported by stcpf_chan and six_tap_clamped_pixel_filter.
package stcpf_pkg;

  // fixed field widths
  localparam int PIX_W      = 16;
  localparam int WGT_W      = 18;
  localparam int DIM_W      = 13;
  localparam int TAP_COUNT  = 6;
  localparam int HIST_DEPTH = TAP_COUNT - 1;
  localparam int TAP_IDX_W  = $clog2(TAP_COUNT);
  localparam int FRAC_BITS  = 14;

  // datapath widths: unsigned pixel times signed weight, six-term sum
  localparam int PROD_W = PIX_W + 1 + WGT_W;
  localparam int SUM_W  = PROD_W + $clog2(TAP_COUNT);
  localparam int RND_W  = SUM_W - FRAC_BITS;

  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic [WGT_W-1:0] WGT_UNITY  = WGT_W'(1) << FRAC_BITS;
  localparam logic [DIM_W-1:0] DIM_RESET  = DIM_W'(4096);

  typedef logic [PIX_W-1:0]        pix_t;
  typedef logic signed [WGT_W-1:0] wgt_t;
  typedef logic [DIM_W-1:0]        dim_t;
  typedef pix_t [TAP_COUNT-1:0]    tap_vec_t;
  typedef wgt_t [TAP_COUNT-1:0]    wgt_vec_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_WEIGHT_TAP0,
    REG_WEIGHT_TAP1,
    REG_WEIGHT_TAP2,
    REG_WEIGHT_TAP3,
    REG_WEIGHT_TAP4,
    REG_WEIGHT_TAP5,
    REG_SOURCE_WIDTH,
    REG_OUTPUT_WIDTH
  } cfg_reg_e;

  // per-stage load strobes shared by all channel datapaths
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } stage_ld_t;

endpackage

// ----- sv/stcpf_chan.sv -----
// One channel of the filter datapath: tap register, products, sum, round and clamp.
// Depends on stcpf_pkg; stage load strobes come from the top level.
module stcpf_chan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stcpf_pkg::stage_ld_t ld_i,
  input  stcpf_pkg::tap_vec_t tap_i,
  input  stcpf_pkg::wgt_vec_t weight_i,
  output stcpf_pkg::pix_t     res_o
);
  import stcpf_pkg::*;

  tap_vec_t                 tap_q;
  logic signed [PROD_W-1:0] prod_q [TAP_COUNT];
  pix_t                     lo2_q, hi2_q, lo3_q, hi3_q;
  logic signed [SUM_W-1:0]  sum_q;
  pix_t                     res_q;

  pix_t                     lo_d, hi_d;
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  rnd_full;
  logic signed [RND_W-1:0]  rnd;
  logic signed [RND_W-1:0]  lo_ext, hi_ext;
  pix_t                     res_d;

  // window min and max over the six taps
  always_comb begin
    lo_d = tap_q[0];
    hi_d = tap_q[0];
    for (int k = 1; k < TAP_COUNT; k++) begin
      if (tap_q[k] < lo_d) lo_d = tap_q[k];
      if (tap_q[k] > hi_d) hi_d = tap_q[k];
    end
  end

  // full-width sum of the products
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < TAP_COUNT; k++) begin
      sum_d = sum_d + SUM_W'(prod_q[k]);
    end
  end

  // round to nearest, floor shift, then clamp to the tap range
  always_comb begin
    rnd_full = sum_q + $signed(ROUND_BIAS);
    rnd      = $signed(rnd_full[SUM_W-1:FRAC_BITS]);
    lo_ext   = $signed(RND_W'(lo3_q));
    hi_ext   = $signed(RND_W'(hi3_q));
    priority if (rnd < lo_ext) begin
      res_d = lo3_q;
    end else if (rnd > hi_ext) begin
      res_d = hi3_q;
    end else begin
      res_d = rnd[PIX_W-1:0];
    end
  end

  // pipeline payload registers
  always_ff @(posedge clk_i) begin
    if (ld_i.ld1) begin
      tap_q <= tap_i;
    end
    if (ld_i.ld2) begin
      for (int k = 0; k < TAP_COUNT; k++) begin
        prod_q[k] <= $signed({1'b0, tap_q[k]}) * $signed(weight_i[k]);
      end
      lo2_q <= lo_d;
      hi2_q <= hi_d;
    end
    if (ld_i.ld3) begin
      sum_q <= sum_d;
      lo3_q <= lo2_q;
      hi3_q <= hi2_q;
    end
    if (ld_i.ld4) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

`ifndef SYNTHESIS
  // a loaded result always lies inside the tap range it was clamped to
  a_res_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_i.ld4 |=> (res_q >= $past(lo3_q)) && (res_q <= $past(hi3_q)))
    else $error("clamped result outside tap range");
  // the window minimum never lies above the window maximum
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_i.ld2 |=> lo2_q <= hi2_q)
    else $error("window minimum above maximum");
  // round stage reads a sum that was loaded from the product stage
  a_sum_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_i.ld3 |=> sum_q == $past(sum_d))
    else $error("sum register did not load");
`endif

endmodule

// ----- sv/six_tap_clamped_pixel_filter.sv -----
// Top level of the six-tap clamped pixel filter: config registers, line control,
// pixel window, pipeline handshake. Depends on stcpf_pkg and stcpf_chan.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------------------
//   cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i / in_ready_o    | in_chan0_i .. in_chan3_i
//   out     | out       | out_valid_o / out_ready_i  | out_chan0_o .. out_chan3_o, end_of_line_o
//
// One slot accepted per cycle while in_ready_o is high; out_valid_o rises when its result reaches the last stage.
// The four stages are tap capture, six multiplies, sum, and round with clamp.
// The first two slots of a line give no result and leave a bubble in the pipeline.
// Reset: weights pass column out_x through, both widths 4096, window and slot count clear.
// Output stalls back up stage by stage; empty stages keep taking slots.
module six_tap_clamped_pixel_filter #(
  parameter int MAX_WIDTH     = 4096,
  parameter int CHANNEL_COUNT = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  stcpf_pkg::cfg_reg_e  cfg_index_i,
  input  stcpf_pkg::wgt_t      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  stcpf_pkg::pix_t      in_chan0_i,
  input  stcpf_pkg::pix_t      in_chan1_i,
  input  stcpf_pkg::pix_t      in_chan2_i,
  input  stcpf_pkg::pix_t      in_chan3_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output stcpf_pkg::pix_t      out_chan0_o,
  output stcpf_pkg::pix_t      out_chan1_o,
  output stcpf_pkg::pix_t      out_chan2_o,
  output stcpf_pkg::pix_t      out_chan3_o,
  output logic                 end_of_line_o
);
  import stcpf_pkg::*;

  localparam int PORT_CHANS = 4;
  localparam int SLOT_W     = $clog2(MAX_WIDTH + 2);
  localparam int CMP_W      = ((SLOT_W > DIM_W) ? SLOT_W : DIM_W) + 1;
  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(MAX_WIDTH + 1);

  // configuration registers
  wgt_vec_t weight_q;
  dim_t     source_width_q, output_width_q;

  // line state
  logic [SLOT_W-1:0] slot_q;
  pix_t              win_q [HIST_DEPTH][CHANNEL_COUNT];

  // pipeline control
  logic      v1_q, v2_q, v3_q, v4_q;
  logic      eol1_q, eol2_q, eol3_q, eol4_q;
  logic      rdy1, rdy2, rdy3, rdy4;
  logic      in_acc;
  stage_ld_t ld;

  // slot decode
  logic [CMP_W-1:0] slot_ext, ow_sat;
  logic             last, emit, in_range;
  pix_t             in_pix [PORT_CHANS];
  pix_t             cur [CHANNEL_COUNT];
  pix_t             res [PORT_CHANS];

  assign cfg_ready_o = 1'b1;

  // configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TAP_COUNT; k++) begin
        weight_q[k] <= (k == int'(REG_WEIGHT_TAP3)) ? WGT_UNITY : '0;
      end
      source_width_q <= DIM_RESET;
      output_width_q <= DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_WEIGHT_TAP0, REG_WEIGHT_TAP1, REG_WEIGHT_TAP2,
        REG_WEIGHT_TAP3, REG_WEIGHT_TAP4, REG_WEIGHT_TAP5: begin
          weight_q[TAP_IDX_W'(cfg_index_i)] <= cfg_data_i;
        end
        REG_SOURCE_WIDTH: begin
          source_width_q <= cfg_data_i[DIM_W-1:0];
        end
        REG_OUTPUT_WIDTH: begin
          output_width_q <= cfg_data_i[DIM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // slot position decode
  always_comb begin
    slot_ext = CMP_W'(slot_q);
    ow_sat   = (CMP_W'(output_width_q) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH)
                                                            : CMP_W'(output_width_q);
    last     = slot_ext >= ow_sat + CMP_W'(1);
    emit     = slot_ext >= CMP_W'(2);
    in_range = slot_ext < CMP_W'(source_width_q);
  end

  assign in_pix[0] = in_chan0_i;
  assign in_pix[1] = in_chan1_i;
  assign in_pix[2] = in_chan2_i;
  assign in_pix[3] = in_chan3_i;

  // current column, zero past the source width
  always_comb begin
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      cur[c] = in_range ? in_pix[c] : '0;
    end
  end

  // ready chain: a stage takes a word when empty or when it moves on
  always_comb begin
    rdy4   = !v4_q || out_ready_i;
    rdy3   = !v3_q || rdy4;
    rdy2   = !v2_q || rdy3;
    rdy1   = !v1_q || rdy2;
    in_acc = in_valid_i && rdy1;
    ld.ld1 = in_acc && emit;
    ld.ld2 = rdy2 && v1_q;
    ld.ld3 = rdy3 && v2_q;
    ld.ld4 = rdy4 && v3_q;
  end

  assign in_ready_o = rdy1;

  // slot counter and pixel window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
          win_q[i][c] <= '0;
        end
      end
    end else if (in_acc) begin
      if (last) begin
        slot_q <= '0;
        for (int i = 0; i < HIST_DEPTH; i++) begin
          for (int c = 0; c < CHANNEL_COUNT; c++) begin
            win_q[i][c] <= '0;
          end
        end
      end else begin
        slot_q <= slot_q + SLOT_W'(1);
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
          win_q[0][c] <= cur[c];
        end
        for (int i = 1; i < HIST_DEPTH; i++) begin
          for (int c = 0; c < CHANNEL_COUNT; c++) begin
            win_q[i][c] <= win_q[i-1][c];
          end
        end
      end
    end
  end

  // stage valid bits and end-of-line flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      eol1_q <= 1'b0;
      eol2_q <= 1'b0;
      eol3_q <= 1'b0;
      eol4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q   <= in_acc && emit;
        eol1_q <= last;
      end
      if (rdy2) begin
        v2_q   <= v1_q;
        eol2_q <= eol1_q;
      end
      if (rdy3) begin
        v3_q   <= v2_q;
        eol3_q <= eol2_q;
      end
      if (rdy4) begin
        v4_q   <= v3_q;
        eol4_q <= eol3_q;
      end
    end
  end

  // per-channel datapaths; unused channels read zero
  for (genvar c = 0; c < PORT_CHANS; c++) begin : g_chan
    if (c < CHANNEL_COUNT) begin : g_used
      tap_vec_t taps;
      always_comb begin
        for (int k = 0; k < HIST_DEPTH; k++) begin
          taps[k] = win_q[HIST_DEPTH-1-k][c];
        end
        taps[TAP_COUNT-1] = cur[c];
      end
      stcpf_chan u_chan (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ld_i     (ld),
        .tap_i    (taps),
        .weight_i (weight_q),
        .res_o    (res[c])
      );
    end else begin : g_unused
      assign res[c] = '0;
    end
  end

  assign out_valid_o   = v4_q;
  assign end_of_line_o = eol4_q;
  assign out_chan0_o   = res[0];
  assign out_chan1_o   = res[1];
  assign out_chan2_o   = res[2];
  assign out_chan3_o   = res[3];

`ifndef SYNTHESIS
  // the slot counter never runs past the last slot of the widest line
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_MAX)
    else $error("slot position out of range");
  // the last slot of a line restarts the count
  a_line_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last) |=> slot_q == '0)
    else $error("line did not restart after last slot");
  // any other accepted slot advances the count by one
  a_slot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !last) |=> slot_q == $past(slot_q) + SLOT_W'(1))
    else $error("slot position did not advance");
  // the two leading slots of a line never enter the pipeline
  a_no_lead_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !emit) |=> !v1_q)
    else $error("leading slot produced a result");
`endif

endmodule
